// ===== design/point_in_polygon_test_macros.svh =====
// assertion macros for the checker file of the point-in-polygon block
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ppt_pkg.sv =====
// shared constants, codes and types of the point-in-polygon block
`default_nettype none

package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  // input word modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // result word locations
  localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [1:0] LOC_INSIDE   = 2'd1;
  localparam logic [1:0] LOC_BOUNDARY = 2'd2;
  localparam logic [1:0] LOC_NONE     = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_t;

  // one edge handed to the edge unit
  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } edge_t;

  // per-edge verdict back from the edge unit
  typedef struct packed {
    logic valid;
    logic last;
    logic on_edge;
    logic crosses;
  } edge_res_t;

endpackage

`default_nettype wire

// ===== design/ppt_in_if.sv =====
// input channel: mode and coordinates with valid/ready
`default_nettype none

interface ppt_in_if;
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  ppt_pkg::coord_t coord_x;
  ppt_pkg::coord_t coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

// ===== design/ppt_out_if.sv =====
// output channel: location and table-full flag with valid/ready
`default_nettype none

interface ppt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] location;
  logic       table_full;

  modport source (output valid, output location, output table_full, input ready);
  modport sink   (input valid, input location, input table_full, output ready);
endinterface

`default_nettype wire

// ===== design/point_in_polygon_test.sv =====
// top level of the point-in-polygon block: vertex store, query sequencer, result register
//
//  channel | dir | word                          | handshake
//  --------+-----+-------------------------------+------------------------------
//  req     | in  | mode, coord_x, coord_y        | valid && ready
//  rsp     | out | location, table_full          | valid && ready
//
//  clear, append and a query on an empty polygon are answered at once, with no vertex read
//  a query on n stored vertices reads them through the single read port of the vertex
//  memory, one vertex per cycle, and sends each edge through the edge unit
//  reset (rst, synchronous) empties the polygon; the vertex memory has no clearing pass
//  req.ready is low while a query runs and while a result waits with rsp.ready low
//  a stalled result holds in the output register; req may be taken in the cycle it leaves
`default_nettype none

module point_in_polygon_test (
  input wire logic  clk,
  input wire logic  rst,
  ppt_in_if.sink    req,
  ppt_out_if.source rsp
);

  localparam int CW = ppt_pkg::COORD_WIDTH;
  localparam int AW = ppt_pkg::ADDR_W;
  localparam int NW = ppt_pkg::CNT_W;

  // vertex memory, {x, y} per entry; written only while idle, so no forwarding
  logic [2*CW-1:0] vmem [ppt_pkg::MAX_VERTICES];
  logic [2*CW-1:0] rd_data;

  ppt_pkg::state_t state, state_next;

  logic [NW-1:0] count;        // stored vertices
  logic [AW-1:0] issue_addr;   // next read address during a query
  logic [AW-1:0] q_last;       // index of the last vertex for this query
  ppt_pkg::coord_t px, py;     // query point

  // read pipeline tags, aligned with rd_data
  logic rd_en;
  logic rd_vld;
  logic rd_first;
  logic rd_last;
  logic close_pend;            // closing edge back to vertex 0 goes next

  ppt_pkg::coord_t prev_x, prev_y;
  ppt_pkg::coord_t v0_x, v0_y;

  ppt_pkg::edge_t     edge_in;
  ppt_pkg::edge_res_t edge_res;

  logic parity;
  logic boundary;

  logic       out_valid;
  logic [1:0] out_loc;
  logic       out_full;

  logic in_ready;
  logic in_acc;
  logic is_query;
  logic is_append;
  logic is_clear;
  logic store_full;

  ppt_pkg::coord_t rd_x, rd_y;

  assign rd_x = rd_data[2*CW-1:CW];
  assign rd_y = rd_data[CW-1:0];

  assign in_acc     = req.valid && in_ready;
  assign is_query   = req.mode == ppt_pkg::MODE_QUERY;
  assign is_append  = req.mode == ppt_pkg::MODE_APPEND;
  assign is_clear   = req.mode == ppt_pkg::MODE_CLEAR;
  assign store_full = count == NW'(ppt_pkg::MAX_VERTICES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppt_pkg::ST_IDLE: begin
        if (in_acc && is_query && (count != '0)) state_next = ppt_pkg::ST_READ;
      end
      ppt_pkg::ST_READ: begin
        if (issue_addr == q_last) state_next = ppt_pkg::ST_DRAIN;
      end
      ppt_pkg::ST_DRAIN: begin
        if (edge_res.valid && edge_res.last) state_next = ppt_pkg::ST_IDLE;
      end
      default: state_next = ppt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    case (state)
      ppt_pkg::ST_IDLE: in_ready = !out_valid || rsp.ready;
      ppt_pkg::ST_READ: rd_en = 1'b1;
      ppt_pkg::ST_DRAIN: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;

  // vertex memory ports
  always_ff @(posedge clk) begin
    if (in_acc && is_append && !store_full) begin
      vmem[count[AW-1:0]] <= {req.coord_x, req.coord_y};
    end
    if (rd_en) begin
      rd_data <= vmem[issue_addr];
    end
  end

  // edge pairing: each read after the first closes an edge with the previous vertex,
  // and in the cycle after the last read data the closing edge returns to vertex 0
  always_comb begin
    edge_in.valid = (rd_vld && !rd_first) || close_pend;
    edge_in.last  = close_pend;
    edge_in.x1    = prev_x;
    edge_in.y1    = prev_y;
    edge_in.x2    = close_pend ? v0_x : rd_x;
    edge_in.y2    = close_pend ? v0_y : rd_y;
  end

  ppt_edge_unit u_edge (
    .clk     (clk),
    .rst     (rst),
    .px      (px),
    .py      (py),
    .edge_in (edge_in),
    .res     (edge_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ppt_pkg::ST_IDLE;
      count      <= '0;
      rd_vld     <= 1'b0;
      rd_first   <= 1'b0;
      rd_last    <= 1'b0;
      close_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_vld     <= rd_en;
      rd_first   <= rd_en && (issue_addr == '0);
      rd_last    <= rd_en && (issue_addr == q_last);
      close_pend <= rd_vld && rd_last;

      if (in_acc) begin
        if (is_clear) begin
          count <= '0;
        end else if (is_append && !store_full) begin
          count <= count + NW'(1);
        end
      end

      // everything but a non-empty query answers at once
      if (in_acc && (!is_query || (count == '0))) begin
        out_valid <= 1'b1;
      end else if (edge_res.valid && edge_res.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end

    // payload, no reset
    if (in_acc) begin
      px       <= req.coord_x;
      py       <= req.coord_y;
      q_last   <= AW'(count - NW'(1));
      parity   <= 1'b0;
      boundary <= 1'b0;
      out_loc  <= is_query ? ppt_pkg::LOC_OUTSIDE : ppt_pkg::LOC_NONE;
      out_full <= is_append && store_full;
    end

    if (in_acc) begin
      issue_addr <= '0;
    end else if (rd_en) begin
      issue_addr <= issue_addr + AW'(1);
    end

    if (rd_vld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    if (rd_vld && rd_first) begin
      v0_x <= rd_x;
      v0_y <= rd_y;
    end

    if (edge_res.valid) begin
      parity   <= parity ^ edge_res.crosses;
      boundary <= boundary || edge_res.on_edge;
    end

    // any edge through the point wins over parity
    if (edge_res.valid && edge_res.last) begin
      out_full <= 1'b0;
      if (boundary || edge_res.on_edge) begin
        out_loc <= ppt_pkg::LOC_BOUNDARY;
      end else if (parity ^ edge_res.crosses) begin
        out_loc <= ppt_pkg::LOC_INSIDE;
      end else begin
        out_loc <= ppt_pkg::LOC_OUTSIDE;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.location   = out_loc;
  assign rsp.table_full = out_full;

endmodule

`default_nettype wire

// ===== design/ppt_edge_unit.sv =====
// three-stage edge test: differences, cross products, compares
`default_nettype none

module ppt_edge_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ppt_pkg::coord_t     px,
  input  wire ppt_pkg::coord_t     py,
  input  wire ppt_pkg::edge_t      edge_in,
  output ppt_pkg::edge_res_t       res
);

  localparam int CW = ppt_pkg::COORD_WIDTH;

  // difference stage
  logic           d_vld;
  logic           d_last;
  ppt_pkg::diff_t d_dy;
  ppt_pkg::diff_t d_dxp;
  ppt_pkg::diff_t d_dx;
  ppt_pkg::diff_t d_dyp;
  logic           d_inbox;
  logic           d_straddle;
  logic           d_dypos;

  // product stage
  logic           m_vld;
  logic           m_last;
  ppt_pkg::prod_t m_lhs;
  ppt_pkg::prod_t m_rhs;
  logic           m_inbox;
  logic           m_straddle;
  logic           m_dypos;

  ppt_pkg::diff_t ex1, ey1, ex2, ey2, epx, epy;
  logic           inbox_x, inbox_y;

  always_comb begin
    ex1 = $signed({edge_in.x1[CW-1], edge_in.x1});
    ey1 = $signed({edge_in.y1[CW-1], edge_in.y1});
    ex2 = $signed({edge_in.x2[CW-1], edge_in.x2});
    ey2 = $signed({edge_in.y2[CW-1], edge_in.y2});
    epx = $signed({px[CW-1], px});
    epy = $signed({py[CW-1], py});
    // point within the edge's bounding box on each axis
    inbox_x = !((px < edge_in.x1) && (px < edge_in.x2)) &&
              !((px > edge_in.x1) && (px > edge_in.x2));
    inbox_y = !((py < edge_in.y1) && (py < edge_in.y2)) &&
              !((py > edge_in.y1) && (py > edge_in.y2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      m_vld <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      d_vld <= edge_in.valid;
      m_vld <= d_vld;
      res.valid <= m_vld;
    end
    d_last     <= edge_in.last;
    d_dy       <= ey2 - ey1;
    d_dxp      <= epx - ex1;
    d_dx       <= ex2 - ex1;
    d_dyp      <= epy - ey1;
    d_inbox    <= inbox_x && inbox_y;
    d_straddle <= (edge_in.y1 > py) != (edge_in.y2 > py);
    d_dypos    <= edge_in.y2 > edge_in.y1;

    m_last     <= d_last;
    m_lhs      <= ppt_pkg::prod_t'(d_dxp) * ppt_pkg::prod_t'(d_dy);
    m_rhs      <= ppt_pkg::prod_t'(d_dx) * ppt_pkg::prod_t'(d_dyp);
    m_inbox    <= d_inbox;
    m_straddle <= d_straddle;
    m_dypos    <= d_dypos;

    // zero cross product is lhs == rhs
    res.last    <= m_last;
    res.on_edge <= m_inbox && (m_lhs == m_rhs);
    res.crosses <= m_straddle && (m_dypos ? (m_lhs < m_rhs) : (m_lhs > m_rhs));
  end

endmodule

`default_nettype wire

// ===== design/ppt_checker.sv =====
// port-level checker for the point-in-polygon block, bound to the top level
`default_nettype none
`include "point_in_polygon_test_macros.svh"

module ppt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_mode,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] rsp_location,
  input wire logic       table_full
);

  `PPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_location) && $stable(table_full), "stalled result word changed")
  `PPT_ASSERT_NEXT(a_quick_answer, req_valid && req_ready && (req_mode != ppt_pkg::MODE_QUERY), rsp_valid, "clear or append gave no result next cycle")
  `PPT_ASSERT_NOW(a_full_no_loc, rsp_valid && table_full, rsp_location == ppt_pkg::LOC_NONE, "dropped append carries a location")
  `PPT_ASSERT_NOW(a_no_take_when_stalled, rsp_valid && !rsp_ready, !req_ready, "input taken while a result is stalled")

endmodule

bind point_in_polygon_test ppt_checker u_ppt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_mode     (req.mode),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_location (rsp.location),
  .table_full   (rsp.table_full)
);

`default_nettype wire
